// ===== src/nmea_pkg.sv =====
`timescale 1ns / 1ps

package nmea_pkg;

    localparam int OUT_W = 200;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_W      = 8'h57;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;

    localparam logic [39:0] NAME_GPRMC = "GPRMC";
    localparam logic [39:0] NAME_GNRMC = "GNRMC";
    localparam logic [39:0] NAME_GPGGA = "GPGGA";
    localparam logic [39:0] NAME_GNGGA = "GNGGA";

    localparam logic [1:0] KIND_RMC   = 2'd0;
    localparam logic [1:0] KIND_GGA   = 2'd1;
    localparam logic [1:0] KIND_OTHER = 2'd2;

    typedef enum logic [1:0] {
        CMD_CHAR,
        CMD_DOLLAR,
        CMD_SEP
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic       is_cs;
        logic [7:0] term_no;
        logic [7:0] parity;
    } q_ctrl_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_DEC,
        OP_DEG,
        OP_INT
    } op_t;

    typedef enum logic [2:0] {
        F_TIME,
        F_LAT,
        F_LON,
        F_SPEED,
        F_CTA,
        F_DATE
    } field_t;

    typedef enum logic [1:0] {
        DIV_100,
        DIV_3,
        DIV_1000
    } div_sel_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_DISP,
        B_WS,
        B_DIG,
        B_POST,
        B_FRAC1,
        B_FRAC2,
        B_DFRAC,
        B_DSTART,
        B_DWAIT,
        B_TM,
        B_WB,
        B_OUT
    } be_state_t;

    function automatic logic [9:0] divisor(input div_sel_t sel);
        logic [9:0] d;
        case (sel)
            DIV_100:  d = 10'd100;
            DIV_3:    d = 10'd3;
            DIV_1000: d = 10'd1000;
            default:  d = 10'd100;
        endcase
        return d;
    endfunction

    function automatic logic [7:0] hex_val(input logic [7:0] a);
        logic [7:0] v;
        if (a >= CH_A && a <= CH_F)
            v = a - CH_A + 8'd10;
        else if (a >= CH_LA && a <= CH_LF_HEX)
            v = a - CH_LA + 8'd10;
        else
            v = a - CH_0;
        return v;
    endfunction

    // weight of the k-th minute fraction digit, in 1e-7 minute
    function automatic logic [31:0] frac_term(input logic [2:0] k, input logic [3:0] d);
        logic [23:0] w;
        case (k)
            3'd0:    w = 24'd1000000;
            3'd1:    w = 24'd100000;
            3'd2:    w = 24'd10000;
            3'd3:    w = 24'd1000;
            3'd4:    w = 24'd100;
            3'd5:    w = 24'd10;
            3'd6:    w = 24'd1;
            default: w = 24'd0;
        endcase
        return 32'(w * d);
    endfunction

endpackage

// ===== src/nmea_div.sv =====
`timescale 1ns / 1ps

module nmea_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [31:0]       dividend,
    input  nmea_pkg::div_sel_t sel,
    output logic              done,
    output logic [31:0]       quot,
    output logic [9:0]        rem
);

    logic [31:0]        x_reg, x_next;
    logic [63:0]        prod_reg, prod_next;
    nmea_pkg::div_sel_t sel_reg, sel_next;
    logic               s1_reg, s1_next;
    logic               done_reg, done_next;
    logic [31:0]        q_reg, q_next;
    logic [9:0]         r_reg, r_next;
    logic [31:0]        magic;
    logic [5:0]         shamt;
    logic [31:0]        q_calc;
    logic [31:0]        back;

    // reciprocal constants, exact for every 32-bit dividend
    always_comb
    begin
        case (sel)
            nmea_pkg::DIV_100:  magic = 32'h51EB851F;
            nmea_pkg::DIV_3:    magic = 32'hAAAAAAAB;
            nmea_pkg::DIV_1000: magic = 32'h10624DD3;
            default:            magic = 32'h51EB851F;
        endcase
    end

    always_comb
    begin
        case (sel_reg)
            nmea_pkg::DIV_100:  shamt = 6'd37;
            nmea_pkg::DIV_3:    shamt = 6'd33;
            nmea_pkg::DIV_1000: shamt = 6'd38;
            default:            shamt = 6'd37;
        endcase
    end

    assign q_calc = 32'(prod_reg >> shamt);
    assign back   = 32'(q_calc * {22'd0, nmea_pkg::divisor(sel_reg)});

    always_comb
    begin
        x_next    = x_reg;
        prod_next = prod_reg;
        sel_next  = sel_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        s1_next   = start;
        done_next = s1_reg;
        if (start)
        begin
            // stage one: multiply by the reciprocal
            x_next    = dividend;
            prod_next = {32'd0, dividend} * {32'd0, magic};
            sel_next  = sel;
        end
        if (s1_reg)
        begin
            // stage two: shift out the quotient, take the remainder
            q_next = q_calc;
            r_next = 10'(x_reg - back);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            s1_reg   <= s1_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        prod_reg <= prod_next;
        sel_reg  <= sel_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

// ===== src/nmea_fe.sv =====
`timescale 1ns / 1ps

module nmea_fe
#(
    parameter int MAXL = 15
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] char_in
    input  logic                  q_full,
    output logic                  push,
    output nmea_pkg::q_ctrl_t     push_ctrl,
    output logic [MAXL*8-1:0]     push_text
);

    localparam int IW = $clog2(MAXL);

    logic [7:0]    tbuf_reg [MAXL];
    logic [7:0]    tbuf_next [MAXL];
    logic [IW-1:0] offset_reg, offset_next;
    logic [7:0]    term_no_reg, term_no_next;
    logic [7:0]    parity_reg, parity_next;
    logic          in_cs_reg, in_cs_next;
    logic          accept;
    logic [7:0]    c;
    logic          is_sep;

    assign accept   = s_tvalid && !q_full;
    assign s_tready = !q_full;
    assign push     = accept;
    assign c        = s_tdata;
    assign is_sep   = (c == nmea_pkg::CH_COMMA) || (c == nmea_pkg::CH_CR) ||
                      (c == nmea_pkg::CH_LF) || (c == nmea_pkg::CH_STAR);

    always_comb
    begin
        tbuf_next    = tbuf_reg;
        offset_next  = offset_reg;
        term_no_next = term_no_reg;
        parity_next  = parity_reg;
        in_cs_next   = in_cs_reg;
        push_ctrl.cmd     = nmea_pkg::CMD_CHAR;
        push_ctrl.is_cs   = in_cs_reg;
        push_ctrl.term_no = term_no_reg;
        if (accept)
        begin
            if (is_sep)
            begin
                push_ctrl.cmd = nmea_pkg::CMD_SEP;
                if (c == nmea_pkg::CH_COMMA)
                    parity_next = parity_reg ^ nmea_pkg::CH_COMMA;
                // terminate the term text
                tbuf_next[offset_reg] = nmea_pkg::CH_NUL;
                term_no_next = term_no_reg + 8'd1;
                offset_next  = '0;
                in_cs_next   = (c == nmea_pkg::CH_STAR);
            end
            else if (c == nmea_pkg::CH_DOLLAR)
            begin
                push_ctrl.cmd = nmea_pkg::CMD_DOLLAR;
                term_no_next = '0;
                offset_next  = '0;
                parity_next  = '0;
                in_cs_next   = 1'b0;
            end
            else
            begin
                // drop characters that would fill the last slot, which is kept for the terminator
                if (offset_reg < IW'(MAXL - 1))
                begin
                    tbuf_next[offset_reg] = c;
                    offset_next = offset_reg + 1'b1;
                end
                if (!in_cs_reg)
                    parity_next = parity_reg ^ c;
            end
        end
        push_ctrl.parity = parity_next;
    end

    always_comb
    begin
        for (int i = 0; i < MAXL; i++)
            push_text[i*8 +: 8] = tbuf_next[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAXL; i++)
                tbuf_reg[i] <= '0;
            offset_reg  <= '0;
            term_no_reg <= '0;
            parity_reg  <= '0;
            in_cs_reg   <= 1'b0;
        end
        else
        begin
            tbuf_reg    <= tbuf_next;
            offset_reg  <= offset_next;
            term_no_reg <= term_no_next;
            parity_reg  <= parity_next;
            in_cs_reg   <= in_cs_next;
        end
    end

endmodule

// ===== src/nmea_q.sv =====
`timescale 1ns / 1ps

module nmea_q
#(
    parameter int W = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         full,
    output logic         valid
);

    logic [W-1:0] mem_reg [2];
    logic         wp_reg, wp_next;
    logic         rp_reg, rp_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic         do_push;
    logic         do_pop;

    assign full     = (cnt_reg == 2'd2);
    assign valid    = (cnt_reg != 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;
    assign pop_data = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = do_push ? !wp_reg : wp_reg;
        rp_next  = do_pop ? !rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wp_reg] <= push_data;
    end

endmodule

// ===== src/nmea_be.sv =====
`timescale 1ns / 1ps

module nmea_be
#(
    parameter int MAXL = 15
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    output logic                       q_pop,
    input  nmea_pkg::q_ctrl_t          q_ctrl,
    input  logic [MAXL*8-1:0]          q_text,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [nmea_pkg::OUT_W-1:0] m_tdata
);

    localparam int IW = $clog2(MAXL);
    localparam int PW = $clog2(MAXL + 1);

    nmea_pkg::be_state_t state_reg, state_next;
    nmea_pkg::q_ctrl_t   ctrl_reg, ctrl_next;
    logic [7:0]          bbuf_reg [MAXL];
    logic [7:0]          bbuf_next [MAXL];
    nmea_pkg::op_t       op_reg, op_next;
    nmea_pkg::field_t    fld_reg, fld_next;
    nmea_pkg::div_sel_t  dph_reg, dph_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic [31:0]         acc_reg, acc_next;
    logic [31:0]         ret_reg, ret_next;
    logic [31:0]         fsum_reg, fsum_next;
    logic [31:0]         hi_reg, hi_next;
    logic [31:0]         tm_reg, tm_next;
    logic [31:0]         dvd_reg, dvd_next;
    logic [2:0]          k_reg, k_next;
    logic                negt_reg, negt_next;
    logic                negd_reg, negd_next;
    logic                skip_reg, skip_next;
    logic                ok_reg, ok_next;
    logic                bad_reg, bad_next;
    logic [1:0]          kind_reg, kind_next;
    logic                fix_reg, fix_next;
    logic [1:0]          hem_reg, hem_next;
    logic [31:0]         field_reg [6];
    logic [31:0]         field_next [6];
    logic                out_valid_reg, out_valid_next;
    logic [nmea_pkg::OUT_W-1:0] out_data_reg, out_data_next;

    logic [7:0]  cur;
    logic [3:0]  dig;
    logic        is_dig;
    logic        is_ws;
    logic        is_sign;
    logic        out_free;
    logic        div_start;
    logic        div_done;
    logic [31:0] div_quot;
    logic [9:0]  div_rem;
    logic [7:0]  hv0;
    logic [7:0]  cs_sum;
    logic [39:0] name5;

    nmea_pkg::op_t    dec_op;
    nmea_pkg::field_t dec_fld;
    logic             dec_fix_wr;
    logic             dec_fix_val;
    logic             dec_hs_wr;
    logic             dec_hw_wr;

    nmea_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_reg),
        .sel      (dph_reg),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    assign cur     = (pos_reg < PW'(MAXL)) ? bbuf_reg[pos_reg[IW-1:0]] : nmea_pkg::CH_NUL;
    assign dig     = cur[3:0];
    assign is_dig  = (cur >= nmea_pkg::CH_0) && (cur <= nmea_pkg::CH_9);
    assign is_ws   = (cur == nmea_pkg::CH_SPACE) || (cur == nmea_pkg::CH_TAB) ||
                     (cur == nmea_pkg::CH_VT) || (cur == nmea_pkg::CH_FF) ||
                     (cur == nmea_pkg::CH_CR) || (cur == nmea_pkg::CH_LF);
    assign is_sign = (cur == nmea_pkg::CH_PLUS) || (cur == nmea_pkg::CH_MINUS);
    assign out_free  = !out_valid_reg || m_tready;
    assign div_start = (state_reg == nmea_pkg::B_DSTART);
    assign q_pop     = (state_reg == nmea_pkg::B_IDLE) && q_valid;
    assign hv0       = nmea_pkg::hex_val(bbuf_reg[0]);
    assign cs_sum    = {hv0[3:0], 4'b0000} + nmea_pkg::hex_val(bbuf_reg[1]);
    assign name5     = {bbuf_reg[0], bbuf_reg[1], bbuf_reg[2], bbuf_reg[3], bbuf_reg[4]};

    // term decode for data terms of RMC and GGA sentences
    always_comb
    begin
        dec_op      = nmea_pkg::OP_NONE;
        dec_fld     = nmea_pkg::F_TIME;
        dec_fix_wr  = 1'b0;
        dec_fix_val = 1'b0;
        dec_hs_wr   = 1'b0;
        dec_hw_wr   = 1'b0;
        if (ctrl_reg.cmd == nmea_pkg::CMD_SEP && !ctrl_reg.is_cs &&
            ctrl_reg.term_no != 8'd0 && bbuf_reg[0] != nmea_pkg::CH_NUL)
        begin
            if (kind_reg == nmea_pkg::KIND_RMC)
            begin
                case (ctrl_reg.term_no)
                    8'd1: begin dec_op = nmea_pkg::OP_DEC; dec_fld = nmea_pkg::F_TIME; end
                    8'd2:
                    begin
                        dec_fix_wr  = 1'b1;
                        dec_fix_val = (bbuf_reg[0] == nmea_pkg::CH_A);
                    end
                    8'd3: begin dec_op = nmea_pkg::OP_DEG; dec_fld = nmea_pkg::F_LAT; end
                    8'd4: dec_hs_wr = 1'b1;
                    8'd5: begin dec_op = nmea_pkg::OP_DEG; dec_fld = nmea_pkg::F_LON; end
                    8'd6: dec_hw_wr = 1'b1;
                    8'd7: begin dec_op = nmea_pkg::OP_DEC; dec_fld = nmea_pkg::F_SPEED; end
                    8'd8: begin dec_op = nmea_pkg::OP_DEC; dec_fld = nmea_pkg::F_CTA; end
                    8'd9: begin dec_op = nmea_pkg::OP_INT; dec_fld = nmea_pkg::F_DATE; end
                    default: dec_op = nmea_pkg::OP_NONE;
                endcase
            end
            else if (kind_reg == nmea_pkg::KIND_GGA)
            begin
                case (ctrl_reg.term_no)
                    8'd1: begin dec_op = nmea_pkg::OP_DEC; dec_fld = nmea_pkg::F_TIME; end
                    8'd2: begin dec_op = nmea_pkg::OP_DEG; dec_fld = nmea_pkg::F_LAT; end
                    8'd3: dec_hs_wr = 1'b1;
                    8'd4: begin dec_op = nmea_pkg::OP_DEG; dec_fld = nmea_pkg::F_LON; end
                    8'd5: dec_hw_wr = 1'b1;
                    8'd6:
                    begin
                        dec_fix_wr  = 1'b1;
                        dec_fix_val = (bbuf_reg[0] > nmea_pkg::CH_0);
                    end
                    8'd9: begin dec_op = nmea_pkg::OP_DEC; dec_fld = nmea_pkg::F_CTA; end
                    default: dec_op = nmea_pkg::OP_NONE;
                endcase
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nmea_pkg::B_IDLE:
                if (q_valid)
                    state_next = nmea_pkg::B_DISP;
            nmea_pkg::B_DISP:
                state_next = (dec_op == nmea_pkg::OP_NONE) ? nmea_pkg::B_OUT : nmea_pkg::B_WS;
            nmea_pkg::B_WS:
                if (!is_ws)
                    state_next = nmea_pkg::B_DIG;
            nmea_pkg::B_DIG:
                if (!is_dig)
                    state_next = nmea_pkg::B_POST;
            nmea_pkg::B_POST:
            begin
                case (op_reg)
                    nmea_pkg::OP_DEC:
                        state_next = (!skip_reg && cur == nmea_pkg::CH_DOT) ?
                                     nmea_pkg::B_FRAC1 : nmea_pkg::B_WB;
                    nmea_pkg::OP_DEG:
                        state_next = (!skip_reg && cur == nmea_pkg::CH_DOT) ?
                                     nmea_pkg::B_DFRAC : nmea_pkg::B_DSTART;
                    default:
                        state_next = nmea_pkg::B_WB;
                endcase
            end
            nmea_pkg::B_FRAC1:
                state_next = is_dig ? nmea_pkg::B_FRAC2 : nmea_pkg::B_WB;
            nmea_pkg::B_FRAC2:
                state_next = nmea_pkg::B_WB;
            nmea_pkg::B_DFRAC:
                if (!is_dig)
                    state_next = nmea_pkg::B_DSTART;
            nmea_pkg::B_DSTART:
                state_next = nmea_pkg::B_DWAIT;
            nmea_pkg::B_DWAIT:
            begin
                if (div_done)
                begin
                    case (dph_reg)
                        nmea_pkg::DIV_100: state_next = nmea_pkg::B_TM;
                        nmea_pkg::DIV_3:   state_next = nmea_pkg::B_DSTART;
                        default:           state_next = nmea_pkg::B_WB;
                    endcase
                end
            end
            nmea_pkg::B_TM:
                state_next = nmea_pkg::B_DSTART;
            nmea_pkg::B_WB:
                state_next = nmea_pkg::B_OUT;
            nmea_pkg::B_OUT:
                if (out_free)
                    state_next = nmea_pkg::B_IDLE;
            default:
                state_next = nmea_pkg::B_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        ctrl_next  = ctrl_reg;
        bbuf_next  = bbuf_reg;
        op_next    = op_reg;
        fld_next   = fld_reg;
        dph_next   = dph_reg;
        pos_next   = pos_reg;
        acc_next   = acc_reg;
        ret_next   = ret_reg;
        fsum_next  = fsum_reg;
        hi_next    = hi_reg;
        tm_next    = tm_reg;
        dvd_next   = dvd_reg;
        k_next     = k_reg;
        negt_next  = negt_reg;
        negd_next  = negd_reg;
        skip_next  = skip_reg;
        ok_next    = ok_reg;
        bad_next   = bad_reg;
        kind_next  = kind_reg;
        fix_next   = fix_reg;
        hem_next   = hem_reg;
        field_next = field_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;
        case (state_reg)
            nmea_pkg::B_IDLE:
            begin
                if (q_valid)
                begin
                    ctrl_next = q_ctrl;
                    for (int i = 0; i < MAXL; i++)
                        bbuf_next[i] = q_text[i*8 +: 8];
                end
            end
            nmea_pkg::B_DISP:
            begin
                ok_next  = 1'b0;
                bad_next = 1'b0;
                op_next  = dec_op;
                fld_next = dec_fld;
                if (ctrl_reg.cmd == nmea_pkg::CMD_DOLLAR)
                begin
                    kind_next = nmea_pkg::KIND_OTHER;
                    fix_next  = 1'b0;
                end
                else if (ctrl_reg.cmd == nmea_pkg::CMD_SEP)
                begin
                    if (ctrl_reg.is_cs)
                    begin
                        ok_next  = (cs_sum == ctrl_reg.parity);
                        bad_next = (cs_sum != ctrl_reg.parity);
                    end
                    else if (ctrl_reg.term_no == 8'd0)
                    begin
                        if (bbuf_reg[5] == nmea_pkg::CH_NUL &&
                            (name5 == nmea_pkg::NAME_GPRMC || name5 == nmea_pkg::NAME_GNRMC))
                            kind_next = nmea_pkg::KIND_RMC;
                        else if (bbuf_reg[5] == nmea_pkg::CH_NUL &&
                            (name5 == nmea_pkg::NAME_GPGGA || name5 == nmea_pkg::NAME_GNGGA))
                            kind_next = nmea_pkg::KIND_GGA;
                        else
                            kind_next = nmea_pkg::KIND_OTHER;
                    end
                end
                if (dec_fix_wr)
                    fix_next = dec_fix_val;
                if (dec_hs_wr)
                    hem_next[0] = (bbuf_reg[0] == nmea_pkg::CH_S);
                if (dec_hw_wr)
                    hem_next[1] = (bbuf_reg[0] == nmea_pkg::CH_W);
                // a leading minus on a decimal term is taken off before the integer read
                negd_next = (dec_op == nmea_pkg::OP_DEC) && (bbuf_reg[0] == nmea_pkg::CH_MINUS);
                pos_next  = ((dec_op == nmea_pkg::OP_DEC) &&
                             (bbuf_reg[0] == nmea_pkg::CH_MINUS)) ? PW'(1) : '0;
                acc_next  = '0;
                negt_next = 1'b0;
                skip_next = 1'b0;
            end
            nmea_pkg::B_WS:
            begin
                if (is_ws)
                begin
                    pos_next  = PW'(pos_reg + 1'b1);
                    skip_next = 1'b1;
                end
                else if (is_sign)
                begin
                    negt_next = (cur == nmea_pkg::CH_MINUS);
                    pos_next  = PW'(pos_reg + 1'b1);
                    skip_next = 1'b1;
                end
            end
            nmea_pkg::B_DIG:
            begin
                if (is_dig)
                begin
                    acc_next = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0} + 32'(dig);
                    pos_next = PW'(pos_reg + 1'b1);
                end
                else if (negt_reg)
                    acc_next = 32'd0 - acc_reg;
            end
            nmea_pkg::B_POST:
            begin
                fsum_next = '0;
                k_next    = '0;
                dvd_next  = acc_reg;
                dph_next  = nmea_pkg::DIV_100;
                case (op_reg)
                    nmea_pkg::OP_DEC: ret_next = 32'(acc_reg * 32'd100);
                    default:          ret_next = acc_reg;
                endcase
                if (!skip_reg && cur == nmea_pkg::CH_DOT)
                    pos_next = PW'(pos_reg + 1'b1);
            end
            nmea_pkg::B_FRAC1:
            begin
                if (is_dig)
                begin
                    ret_next = ret_reg + {dig, 3'b000} + {3'b000, dig, 1'b0};
                    pos_next = PW'(pos_reg + 1'b1);
                end
            end
            nmea_pkg::B_FRAC2:
            begin
                if (is_dig)
                    ret_next = ret_reg + 32'(dig);
            end
            nmea_pkg::B_DFRAC:
            begin
                if (is_dig)
                begin
                    fsum_next = fsum_reg + nmea_pkg::frac_term(k_reg, dig);
                    if (k_reg != 3'd7)
                        k_next = k_reg + 3'd1;
                    pos_next = PW'(pos_reg + 1'b1);
                end
            end
            nmea_pkg::B_DWAIT:
            begin
                if (div_done)
                begin
                    case (dph_reg)
                        nmea_pkg::DIV_100:
                        begin
                            hi_next = div_quot;
                            tm_next = 32'(div_rem * 32'd10000000) + fsum_reg;
                        end
                        nmea_pkg::DIV_3:
                        begin
                            dvd_next = div_quot;
                            dph_next = nmea_pkg::DIV_1000;
                        end
                        default:
                        begin
                            ret_next  = 32'(hi_reg * 32'd1000000) + div_quot;
                            negd_next = 1'b0;
                        end
                    endcase
                end
            end
            nmea_pkg::B_TM:
            begin
                dvd_next = {tm_reg[29:0], 2'b00} + tm_reg + 32'd1;
                dph_next = nmea_pkg::DIV_3;
            end
            nmea_pkg::B_WB:
                field_next[fld_reg] = negd_reg ? (32'd0 - ret_reg) : ret_reg;
            nmea_pkg::B_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, field_reg[nmea_pkg::F_DATE],
                                      field_reg[nmea_pkg::F_CTA], field_reg[nmea_pkg::F_SPEED],
                                      hem_reg[1], hem_reg[0],
                                      field_reg[nmea_pkg::F_LON], field_reg[nmea_pkg::F_LAT],
                                      field_reg[nmea_pkg::F_TIME], fix_reg, kind_reg,
                                      bad_reg, ok_reg};
                end
            end
            default:
                ok_next = ok_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nmea_pkg::B_IDLE;
            ok_reg        <= 1'b0;
            bad_reg       <= 1'b0;
            kind_reg      <= nmea_pkg::KIND_OTHER;
            fix_reg       <= 1'b0;
            hem_reg       <= '0;
            for (int i = 0; i < 6; i++)
                field_reg[i] <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ok_reg        <= ok_next;
            bad_reg       <= bad_next;
            kind_reg      <= kind_next;
            fix_reg       <= fix_next;
            hem_reg       <= hem_next;
            field_reg     <= field_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctrl_reg     <= ctrl_next;
        bbuf_reg     <= bbuf_next;
        op_reg       <= op_next;
        fld_reg      <= fld_next;
        dph_reg      <= dph_next;
        pos_reg      <= pos_next;
        acc_reg      <= acc_next;
        ret_reg      <= ret_next;
        fsum_reg     <= fsum_next;
        hi_reg       <= hi_next;
        tm_reg       <= tm_next;
        dvd_reg      <= dvd_next;
        k_reg        <= k_next;
        negt_reg     <= negt_next;
        negd_reg     <= negd_next;
        skip_reg     <= skip_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nmea_pkg::B_OUT && out_free) |=> out_valid_reg)
        else $error("result not loaded into output register");

    a_ok_bad: assert property (@(posedge clk) disable iff (!rst_n)
        !(ok_reg && bad_reg))
        else $error("checksum pass and fail together");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == nmea_pkg::B_DWAIT))
        else $error("divider finished outside wait state");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg == nmea_pkg::B_DISP))
        else $error("popped item not dispatched");

endmodule

// ===== src/nmea_sentence_parser_top.sv =====
`timescale 1ns / 1ps

// NMEA 0183 RMC/GGA parser: one character per item in, one result item out for
// every character. The front end buffers term text and keeps the checksum parity;
// a two-item queue feeds a back-end sequencer that converts terms. Plain characters
// and separators that convert nothing pass through the back end's pop, dispatch and
// output load steps; a decimal or date term also walks the buffer one character a
// cycle; a latitude or longitude term adds three constant divisions, each done by a
// two-stage reciprocal multiply. A stalled result holds the back end in its output step.
module nmea_sentence_parser_top
#(
    parameter int MAX_TERM_LEN = 15
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] char_in
    output logic         m_tvalid,
    input  logic         m_tready,
    // [0] sentence_ok, [1] checksum_bad, [3:2] sentence_kind, [4] has_fix,
    // [36:5] time_centi, [68:37] latitude_micro, [100:69] longitude_micro,
    // [101] lat_south, [102] lon_west, [134:103] speed_centi,
    // [166:135] course_or_altitude_centi, [198:167] date_value, [199] zero
    output logic [199:0] m_tdata
);

    localparam int QW = $bits(nmea_pkg::q_ctrl_t) + MAX_TERM_LEN * 8;

    logic                      q_full;
    logic                      q_push;
    logic                      q_pop;
    logic                      q_valid;
    nmea_pkg::q_ctrl_t         push_ctrl;
    nmea_pkg::q_ctrl_t         pop_ctrl;
    logic [MAX_TERM_LEN*8-1:0] push_text;
    logic [MAX_TERM_LEN*8-1:0] pop_text;
    logic [QW-1:0]             pop_data;

    nmea_fe #(.MAXL(MAX_TERM_LEN)) u_fe
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .push      (q_push),
        .push_ctrl (push_ctrl),
        .push_text (push_text)
    );

    nmea_q #(.W(QW)) u_q
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_ctrl, push_text}),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .valid     (q_valid)
    );

    assign pop_ctrl = pop_data[QW-1 -: $bits(nmea_pkg::q_ctrl_t)];
    assign pop_text = pop_data[MAX_TERM_LEN*8-1:0];

    nmea_be #(.MAXL(MAX_TERM_LEN)) u_be
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_ctrl   (pop_ctrl),
        .q_text   (pop_text),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== tb/nmea_checker.sv =====
`timescale 1ns / 1ps

module nmea_checker
    import nmea_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [199:0] m_tdata,
    output int           fail_count,
    output int           pending,
    output int           results_seen,
    output int           passes_seen,
    output int           fails_seen
);

    localparam int TERM_LEN = 15;

    logic [7:0]  buf_q [TERM_LEN];
    int unsigned ofs;
    logic [7:0]  term_no;
    logic [7:0]  parity;
    logic        in_cs;
    logic [1:0]  kind;
    logic        fix;
    logic [31:0] t_time, t_lat, t_lon, t_spd, t_cta, t_date;
    logic        south, west;
    logic [199:0] expected_results [$];

    function automatic logic [7:0] ch(int unsigned i);
        return (i < TERM_LEN) ? buf_q[i] : 8'h00;
    endfunction

    function automatic logic digit(logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic logic [31:0] atol_at(int unsigned pos);
        logic [31:0] acc;
        logic        neg;
        acc = 0;
        neg = 0;
        while (ch(pos) == CH_SPACE || ch(pos) == CH_TAB || ch(pos) == CH_VT ||
               ch(pos) == CH_FF || ch(pos) == CH_CR || ch(pos) == CH_LF)
            pos++;
        if (ch(pos) == CH_PLUS || ch(pos) == CH_MINUS)
        begin
            neg = (ch(pos) == CH_MINUS);
            pos++;
        end
        while (digit(ch(pos)))
        begin
            acc = acc * 10 + 32'(ch(pos) - CH_0);
            pos++;
        end
        return neg ? -acc : acc;
    endfunction

    function automatic logic [31:0] centi_value();
        int unsigned pos;
        logic        neg;
        logic [31:0] r;
        neg = (ch(0) == CH_MINUS);
        pos = neg ? 1 : 0;
        r = 100 * atol_at(pos);
        while (digit(ch(pos)))
            pos++;
        if (ch(pos) == CH_DOT && digit(ch(pos + 1)))
        begin
            r += 10 * 32'(ch(pos + 1) - CH_0);
            if (digit(ch(pos + 2)))
                r += 32'(ch(pos + 2) - CH_0);
        end
        return neg ? -r : r;
    endfunction

    function automatic logic [31:0] micro_degrees();
        logic [31:0] whole, mult, tm, bil;
        int unsigned pos;
        whole = atol_at(0);
        mult = 32'd10000000;
        tm = (whole % 100) * mult;
        pos = 0;
        while (digit(ch(pos)))
            pos++;
        if (ch(pos) == CH_DOT)
        begin
            pos++;
            while (digit(ch(pos)))
            begin
                mult = mult / 10;
                tm += 32'(ch(pos) - CH_0) * mult;
                pos++;
            end
        end
        bil = (5 * tm + 1) / 3;
        return (whole / 100) * 1000000 + bil / 1000;
    endfunction

    function automatic logic [7:0] nibble(logic [7:0] a);
        if (a >= CH_A && a <= CH_F)
            return a - CH_A + 8'd10;
        if (a >= CH_LA && a <= CH_LF_HEX)
            return a - CH_LA + 8'd10;
        return a - CH_0;
    endfunction

    function automatic logic name_match(logic [39:0] nm);
        for (int i = 0; i < 5; i++)
            if (ch(i) != nm[8*(4-i) +: 8])
                return 0;
        return ch(5) == 8'h00;
    endfunction

    // returns 1 on checksum pass, 2 on checksum fail, 0 for any other term
    function automatic int close_term();
        logic [7:0] c0;
        logic [7:0] sum;
        c0 = ch(0);
        if (in_cs)
        begin
            sum = 8'(16 * nibble(ch(0)) + nibble(ch(1)));
            return (sum == parity) ? 1 : 2;
        end
        if (term_no == 0)
        begin
            if (name_match(NAME_GPRMC) || name_match(NAME_GNRMC))
                kind = KIND_RMC;
            else if (name_match(NAME_GPGGA) || name_match(NAME_GNGGA))
                kind = KIND_GGA;
            else
                kind = KIND_OTHER;
            return 0;
        end
        if (c0 == 8'h00)
            return 0;
        if (kind == KIND_RMC)
        begin
            case (term_no)
                1: t_time = centi_value();
                2: fix = (c0 == CH_A);
                3: t_lat = micro_degrees();
                4: south = (c0 == CH_S);
                5: t_lon = micro_degrees();
                6: west = (c0 == CH_W);
                7: t_spd = centi_value();
                8: t_cta = centi_value();
                9: t_date = atol_at(0);
                default: ;
            endcase
        end
        else if (kind == KIND_GGA)
        begin
            case (term_no)
                1: t_time = centi_value();
                2: t_lat = micro_degrees();
                3: south = (c0 == CH_S);
                4: t_lon = micro_degrees();
                5: west = (c0 == CH_W);
                6: fix = (c0 > CH_0);
                9: t_cta = centi_value();
                default: ;
            endcase
        end
        return 0;
    endfunction

    function automatic logic [199:0] advance_parser(logic [7:0] c);
        int ev;
        logic [199:0] r;
        ev = 0;
        if (c == CH_COMMA || c == CH_CR || c == CH_LF || c == CH_STAR)
        begin
            if (c == CH_COMMA)
                parity ^= CH_COMMA;
            if (ofs < TERM_LEN)
            begin
                buf_q[ofs] = 8'h00;
                ev = close_term();
            end
            term_no = term_no + 8'd1;
            ofs = 0;
            in_cs = (c == CH_STAR);
        end
        else if (c == CH_DOLLAR)
        begin
            term_no = 0;
            ofs = 0;
            parity = 0;
            kind = KIND_OTHER;
            in_cs = 0;
            fix = 0;
        end
        else
        begin
            if (ofs < TERM_LEN - 1)
            begin
                buf_q[ofs] = c;
                ofs++;
            end
            if (!in_cs)
                parity ^= c;
        end
        r = '0;
        r[0] = (ev == 1);
        r[1] = (ev == 2);
        r[3:2] = kind;
        r[4] = fix;
        r[36:5] = t_time;
        r[68:37] = t_lat;
        r[100:69] = t_lon;
        r[101] = south;
        r[102] = west;
        r[134:103] = t_spd;
        r[166:135] = t_cta;
        r[198:167] = t_date;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [199:0] want;
        if (!rst_n)
        begin
            for (int i = 0; i < TERM_LEN; i++)
                buf_q[i] = 8'h00;
            ofs = 0;
            term_no = 0;
            parity = 0;
            in_cs = 0;
            kind = KIND_OTHER;
            fix = 0;
            {t_time, t_lat, t_lon, t_spd, t_cta, t_date} = '0;
            south = 0;
            west = 0;
            expected_results.delete();
            fail_count = 0;
            pending = 0;
            results_seen = 0;
            passes_seen = 0;
            fails_seen = 0;
        end
        else
        begin
            // check before predicting so a same-edge input cannot shadow the oldest item
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("tb: unexpected result item %h", m_tdata);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata[0])
                        passes_seen++;
                    if (m_tdata[1])
                        fails_seen++;
                    if (want !== m_tdata)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("tb: mismatch ok %b/%b bad %b/%b kind %0d/%0d fix %b/%b time %h/%h lat %h/%h lon %h/%h s %b/%b w %b/%b spd %h/%h cta %h/%h date %h/%h",
                                want[0], m_tdata[0], want[1], m_tdata[1],
                                want[3:2], m_tdata[3:2], want[4], m_tdata[4],
                                want[36:5], m_tdata[36:5], want[68:37], m_tdata[68:37],
                                want[100:69], m_tdata[100:69], want[101], m_tdata[101],
                                want[102], m_tdata[102], want[134:103], m_tdata[134:103],
                                want[166:135], m_tdata[166:135],
                                want[198:167], m_tdata[198:167]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(advance_parser(s_tdata));
            pending = expected_results.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import nmea_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [199:0] m_tdata;
    int           fail_count;
    int           pending;
    int           results_seen;
    int           passes_seen;
    int           fails_seen;
    int           idle_cycles;
    int           chars_sent;
    logic         calm;

    localparam int WATCHDOG = 20000;

    nmea_sentence_parser_top uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    nmea_checker chk
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .fail_count(fail_count),
        .pending(pending),
        .results_seen(results_seen),
        .passes_seen(passes_seen),
        .fails_seen(fails_seen)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // stall the result side at random except during the calm stretch
    always @(negedge clk)
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 16);

    // watchdog: count cycles in which nothing moves
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("tb: watchdog expired");
            $display("tb: done, errors");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after the accept
    task automatic push_char(input logic [7:0] c);
        if (!calm)
            while ($urandom_range(99) < 16)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endtask

    function automatic logic [7:0] hex_digit(input logic [3:0] v, input logic low);
        if (v < 10)
            return CH_0 + v;
        return (low ? CH_LA : CH_A) + v - 4'd10;
    endfunction

    function automatic string rand_digits(input int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++)
            s = {s, string'(byte'(CH_0 + $urandom_range(9)))};
        return s;
    endfunction

    function automatic string rand_term(input int idx, input logic is_gga);
        string s;
        int    r;
        r = $urandom_range(99);
        if (r < 8)
            return "";
        if (r < 14)
        begin
            s = "";
            for (int i = 0; i < $urandom_range(1, 20); i++)
                s = {s, string'(byte'($urandom_range(32, 126)))};
            return s;
        end
        case (idx)
            2: s = is_gga ? {rand_digits($urandom_range(1, 5)), ".", rand_digits($urandom_range(0, 9))}
                          : (($urandom_range(1)) ? "A" : "V");
            3: s = is_gga ? (($urandom_range(1)) ? "S" : "N")
                          : {rand_digits($urandom_range(1, 5)), ".", rand_digits($urandom_range(0, 9))};
            4: s = is_gga ? {rand_digits($urandom_range(1, 5)), ".", rand_digits($urandom_range(0, 9))}
                          : (($urandom_range(1)) ? "S" : "N");
            5: s = is_gga ? (($urandom_range(1)) ? "W" : "E")
                          : {rand_digits($urandom_range(1, 5)), ".", rand_digits($urandom_range(0, 9))};
            6: s = is_gga ? string'(byte'(CH_0 + $urandom_range(9)))
                          : (($urandom_range(1)) ? "W" : "E");
            9: s = {($urandom_range(3) == 0) ? "-" : "", rand_digits($urandom_range(1, 12)),
                    ($urandom_range(1)) ? {".", rand_digits($urandom_range(1, 3))} : ""};
            default: s = {($urandom_range(5) == 0) ? "-" : "", rand_digits($urandom_range(1, 10)),
                          ".", rand_digits($urandom_range(0, 3))};
        endcase
        return s;
    endfunction

    // send one sentence with random field content; corrupt the checksum now and then
    task automatic push_sentence();
        string names [6];
        string body;
        logic  is_gga;
        int    pick;
        logic [7:0] cs;
        names = '{"GPRMC", "GNRMC", "GPGGA", "GNGGA", "GPGSV", "GPRMB"};
        pick = $urandom_range(5);
        is_gga = (pick == 2 || pick == 3);
        body = names[pick];
        for (int t = 1; t <= $urandom_range(6, 12); t++)
            body = {body, ",", rand_term(t, is_gga)};
        cs = 0;
        for (int i = 0; i < body.len(); i++)
            cs ^= body[i];
        if ($urandom_range(4) == 0)
            cs ^= 8'($urandom_range(1, 255));
        push_char(CH_DOLLAR);
        push_text(body);
        push_char(CH_STAR);
        push_char(hex_digit(cs[7:4], 1'($urandom_range(1))));
        push_char(hex_digit(cs[3:0], 1'($urandom_range(1))));
        push_char(CH_CR);
        push_char(CH_LF);
    endtask

    initial
    begin
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = 0;
        m_tready = 0;
        calm = 0;
        chars_sent = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: text before any start mark, known sentences, odd checksum forms
        push_text("GPRMC,1,A,");
        push_text("$GPRMC,235959.99,A,8959.9999999,S,17959.99999,W,999.99,359.9,311299*");
        push_text("00\r\n");
        push_text("$GNGGA,-1.5,0000.0,N,12345678901234567,E,9,,,-4294967.29*7g\r\n");
        push_text("$X*a\n$*\n");
        push_char(8'h00);
        push_char(8'hFF);
        push_char(8'h80);
        push_char(8'h7F);
        push_char(8'h01);

        // random: mostly well-formed sentences, a little line noise between them
        while (chars_sent < 1350)
        begin
            if (chars_sent > 400 && chars_sent < 700)
                calm = 1;
            else
                calm = 0;
            if ($urandom_range(9) == 0)
                for (int i = 0; i < $urandom_range(1, 8); i++)
                    push_char(8'($urandom_range(255)));
            else
                push_sentence();
            // force the term counter past 255 once
            if (chars_sent > 900 && chars_sent < 1000)
                repeat (260) push_char(CH_COMMA);
        end
        s_tvalid <= 1'b0;

        calm = 0;
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        $display("tb: %0d characters sent, %0d result items checked", chars_sent, results_seen);
        $display("tb: %0d checksum passes and %0d checksum failures seen", passes_seen, fails_seen);
        if (fail_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
